/* rtl/region_bin_occupancy_lister_top_defines.svh */
// Assertion macros shared by the region bin occupancy lister RTL.
// Both forms sample on the rising edge of clk; the first one is quiet
// while arst_n is low, the second one also checks during reset.
`ifndef REGION_BIN_OCCUPANCY_LISTER_TOP_DEFINES_SVH
`define REGION_BIN_OCCUPANCY_LISTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RBOL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define RBOL_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define RBOL_ASSERT(lbl, prop, msg)
`define RBOL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/rbol_pkg.sv */
`timescale 1ns / 1ps

package rbol_pkg;

	// Grid limits
	localparam int MAX_BINS   = 8;
	localparam int CNT_W      = 4;   // holds 0..MAX_BINS+1
	localparam int IDX_W      = 6;   // linear bin index
	localparam int TOUCH_W    = 7;   // 0..64
	localparam int NUM_W      = 35;  // signed numerator of one division
	localparam int BSIZE_W    = 31;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_BSIZE_X  = 3'd2;
	localparam logic [2:0] REG_BSIZE_Y  = 3'd3;
	localparam logic [2:0] REG_BINS_X   = 3'd4;
	localparam logic [2:0] REG_BINS_Y   = 3'd5;

	// Command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_BIN  = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	// Request to the shared divider
	typedef struct packed {
		logic                  start;
		logic [NUM_W-1:0]      num;
		logic [BSIZE_W-1:0]    den;
	} div_req_t;

	// Status from the shared divider
	typedef struct packed {
		logic                  done;
		logic                  neg;
		logic [CNT_W-1:0]      quo;
	} div_res_t;

endpackage

/* rtl/rbol_div.sv */
`timescale 1ns / 1ps
`include "region_bin_occupancy_lister_top_defines.svh"

// Floor division by repeated subtraction, quotient capped at MAX_BINS.
// A negative numerator finishes at once with neg set.
module rbol_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rbol_pkg::div_req_t req,
	output rbol_pkg::div_res_t res
);
	import rbol_pkg::*;

	logic                       busy_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           quo_q;
	logic [NUM_W-2:0]           rem_q;
	logic [BSIZE_W-1:0]         den_q;
	logic                       step;

	// One subtraction per cycle while the divisor still fits and the quotient is below MAX_BINS
	assign step = busy_q && !neg_q && (rem_q >= {3'b000, den_q})
		&& (quo_q < CNT_W'(MAX_BINS));

	assign res.done = busy_q && !step;
	assign res.neg  = neg_q;
	assign res.quo  = quo_q;

	// Control and quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			quo_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			neg_q  <= req.num[NUM_W-1];
			quo_q  <= '0;
		end else if (step) begin
			quo_q <= quo_q + CNT_W'(1);
		end else if (busy_q) begin
			busy_q <= 1'b0;
		end
	end

	// Remainder and divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-2:0];
			den_q <= req.den;
		end else if (step) begin
			rem_q <= rem_q - {3'b000, den_q};
		end
	end

	`RBOL_ASSERT(a_start_idle, req.start |-> !busy_q, "divider started while busy")
	`RBOL_ASSERT(a_quo_cap, busy_q |-> (quo_q <= CNT_W'(MAX_BINS)), "quotient above cap")
	`RBOL_ASSERT(a_done_ends, (res.done && !req.start) |=> !busy_q, "divider kept running")

endmodule

/* rtl/region_bin_occupancy_lister_top.sv */
`timescale 1ns / 1ps
// Sequence: an accept state, then four capped divisions on one shared subtract unit,
// a setup state, one walk step per bin of the clamped range (up to 64), a step to leave
// the walk and a finish state; output stalls can hold the walk and the finish.
// Throughput: one item at a time; the next beat is taken after the last result is loaded.
// Reset (arst_n low): presence bitmap cleared, origins 0, bin sizes and counts 1.
`include "region_bin_occupancy_lister_top_defines.svh"

module region_bin_occupancy_lister_top (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // offset_x[31:0], offset_y[63:32], size_x[94:64],
	                               // size_y[125:95], zero[127:126]
	input  logic         s_tuser,  // command
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,  // bin_index[5:0], bins_touched[12:6], zero[15:13]
	output logic [1:0]   m_tuser,  // kind
	output logic         m_tlast
);
	import rbol_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_WAIT   = 3'd2;
	localparam logic [2:0] S_SETUP  = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	// configuration
	logic signed [31:0]    origin_x_q, origin_y_q;
	logic [BSIZE_W-1:0]    bsize_x_q, bsize_y_q;
	logic [3:0]            bins_x_q, bins_y_q;

	// item
	logic                  cmd_q;
	logic signed [31:0]    off_x_q, off_y_q;
	logic [BSIZE_W-1:0]    size_x_q, size_y_q;

	// sequencer
	logic [2:0]            state_q;
	logic [1:0]            d_q;
	logic [CNT_W-1:0]      fx_q, sx_q, fy_q, sy_q;
	logic [CNT_W-1:0]      ix_q, iy_q;
	logic [TOUCH_W-1:0]    cnt_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic [TOUCH_W-1:0]    pend_cnt_q;
	logic [63:0]           present_q;

	// output register
	logic                  out_valid_q;
	logic [1:0]            out_kind_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic [TOUCH_W-1:0]    out_cnt_q;
	logic                  out_last_q;

	div_req_t              dreq;
	div_res_t              dres;

	logic [CNT_W-1:0]      nx, ny, n_sel;
	logic [BSIZE_W-1:0]    bs_sel, sz_sel;
	logic signed [31:0]    off_sel, org_sel;
	logic signed [NUM_W-1:0] rel;
	logic [CNT_W-1:0]      q_inc, s_val, f_val, fx_c, fy_c;
	logic [7:0]            lin_w;
	logic [IDX_W-1:0]      lin;
	logic                  in_rng, hit, row_end, can_load, walk_go;
	logic                  out_load;
	logic [1:0]            out_kind_d;
	logic [IDX_W-1:0]      out_idx_d;
	logic [TOUCH_W-1:0]    out_cnt_d;
	logic                  out_last_d;

	rbol_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.res    (dres)
	);

	// Saturate bin counts to the grid size
	assign nx = (bins_x_q > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : bins_x_q;
	assign ny = (bins_y_q > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : bins_y_q;

	// Select the dimension of the current division
	always_comb begin
		if (d_q[1]) begin
			off_sel = off_y_q;
			org_sel = origin_y_q;
			bs_sel  = (bsize_y_q == '0) ? BSIZE_W'(1) : bsize_y_q;
			sz_sel  = size_y_q;
			n_sel   = ny;
		end else begin
			off_sel = off_x_q;
			org_sel = origin_x_q;
			bs_sel  = (bsize_x_q == '0) ? BSIZE_W'(1) : bsize_x_q;
			sz_sel  = size_x_q;
			n_sel   = nx;
		end
	end

	// Numerator: offset minus origin, plus size minus one for the stop bound
	assign rel = {{3{off_sel[31]}}, off_sel} - {{3{org_sel[31]}}, org_sel};
	assign dreq.start = (state_q == S_START);
	assign dreq.num   = d_q[0] ? (rel + {4'b0000, sz_sel} - NUM_W'(1)) : rel;
	assign dreq.den   = bs_sel;

	// Clamp the division result to the grid
	assign q_inc = dres.quo + CNT_W'(1);
	assign f_val = dres.neg ? '0 : dres.quo;
	assign s_val = (sz_sel == '0 || dres.neg) ? '0 : ((q_inc > n_sel) ? n_sel : q_inc);
	assign fx_c  = (fx_q > sx_q) ? sx_q : fx_q;
	assign fy_c  = (fy_q > sy_q) ? sy_q : fy_q;

	// Walk position
	assign lin_w    = 8'(ix_q) * 8'(ny) + 8'(iy_q);
	assign lin      = lin_w[IDX_W-1:0];
	assign in_rng   = (ix_q < sx_q) && (iy_q < sy_q);
	assign hit      = present_q[lin];
	assign row_end  = ((iy_q + CNT_W'(1)) >= sy_q);
	assign can_load = !out_valid_q || m_tready;
	assign walk_go  = in_rng && (cmd_q == CMD_ADD || !hit || !pend_valid_q || can_load);

	// Load the output register
	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_BIN;
		out_idx_d  = pend_idx_q;
		out_cnt_d  = pend_cnt_q;
		out_last_d = 1'b0;
		case (state_q)
			S_WALK: begin
				if (in_rng && cmd_q == CMD_QUERY && hit && pend_valid_q && can_load)
					out_load = 1'b1;
			end
			S_FINISH: begin
				out_load   = can_load;
				out_last_d = 1'b1;
				if (cmd_q == CMD_ADD) begin
					out_kind_d = KIND_ADD;
					out_idx_d  = '0;
					out_cnt_d  = cnt_q;
				end else if (!pend_valid_q) begin
					out_kind_d = KIND_NONE;
					out_idx_d  = '0;
					out_cnt_d  = '0;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			bsize_x_q  <= BSIZE_W'(1);
			bsize_y_q  <= BSIZE_W'(1);
			bins_x_q   <= 4'd1;
			bins_y_q   <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_BSIZE_X:  bsize_x_q  <= cfg_data[BSIZE_W-1:0];
				REG_BSIZE_Y:  bsize_y_q  <= cfg_data[BSIZE_W-1:0];
				REG_BINS_X:   bins_x_q   <= cfg_data[3:0];
				REG_BINS_Y:   bins_y_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= s_tuser;
			off_x_q  <= s_tdata[31:0];
			off_y_q  <= s_tdata[63:32];
			size_x_q <= s_tdata[94:64];
			size_y_q <= s_tdata[125:95];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			d_q          <= '0;
			fx_q         <= '0;
			sx_q         <= '0;
			fy_q         <= '0;
			sy_q         <= '0;
			ix_q         <= '0;
			iy_q         <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			pend_cnt_q   <= '0;
			present_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						d_q     <= '0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (dres.done) begin
						case (d_q)
							2'd0: fx_q <= f_val;
							2'd1: sx_q <= s_val;
							2'd2: fy_q <= f_val;
							default: sy_q <= s_val;
						endcase
						d_q     <= d_q + 2'd1;
						state_q <= (d_q == 2'd3) ? S_SETUP : S_START;
					end
				end
				S_SETUP: begin
					fx_q         <= fx_c;
					fy_q         <= fy_c;
					ix_q         <= fx_c;
					iy_q         <= fy_c;
					cnt_q        <= '0;
					pend_valid_q <= 1'b0;
					state_q      <= S_WALK;
				end
				S_WALK: begin
					if (!in_rng) begin
						state_q <= S_FINISH;
					end else if (walk_go) begin
						// mark or list this bin, then step row-major
						if (cmd_q == CMD_ADD) begin
							present_q[lin] <= 1'b1;
							cnt_q          <= cnt_q + TOUCH_W'(1);
						end else if (hit) begin
							pend_valid_q <= 1'b1;
							pend_idx_q   <= lin;
							pend_cnt_q   <= cnt_q + TOUCH_W'(1);
							cnt_q        <= cnt_q + TOUCH_W'(1);
						end
						if (row_end) begin
							iy_q <= fy_q;
							ix_q <= ix_q + CNT_W'(1);
						end else begin
							iy_q <= iy_q + CNT_W'(1);
						end
					end
				end
				S_FINISH: begin
					if (can_load) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_idx_q  <= out_idx_d;
			out_cnt_q  <= out_cnt_d;
			out_last_q <= out_last_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_cnt_q, out_idx_q};

	`RBOL_ASSERT(a_walk_in_grid, (state_q == S_WALK && in_rng) |-> (lin_w < 8'd64), "walk left grid")
	`RBOL_ASSERT(a_none_is_last, (m_tvalid && m_tuser == KIND_NONE) |-> (m_tlast && out_cnt_q == '0), "empty query beat malformed")
	`RBOL_ASSERT_RST(a_idle_no_pend, (state_q == S_IDLE) |-> !pend_valid_q, "pending bin left behind")

endmodule
